>>> sv/rscb_pkg.sv
// shared types and constants for the run-length sprite clip blitter
// no dependencies; imported by rle_sprite_clip_blitter_top and the testbench
`timescale 1ns / 1ps
`default_nettype none

package rscb_pkg;

  // tile geometry
  localparam int unsigned TILE_BASE_HEIGHT = 32;
  localparam int unsigned TILE_WIDTH       = 64;

  // coordinate limits for 12 bit saturation
  localparam logic signed [11:0] COORD_MAX = 12'sd2047;
  localparam logic signed [11:0] COORD_MIN = -12'sd2048;

  // clip register reset values
  localparam logic [9:0] CLIP_LEFT_RST   = 10'd0;
  localparam logic [9:0] CLIP_TOP_RST    = 10'd0;
  localparam logic [9:0] CLIP_RIGHT_RST  = 10'd639;
  localparam logic [9:0] CLIP_BOTTOM_RST = 10'd479;

  // register indexes on the config port
  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // stream opcodes
  localparam logic [7:0] OP_RUN    = 8'd0;
  localparam logic [7:0] OP_SKIP   = 8'd1;
  localparam logic [7:0] OP_NEWROW = 8'd2;
  localparam logic [7:0] OP_END    = 8'd3;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_OPCODE   = 3'd1,
    PH_RUN_LEN  = 3'd2,
    PH_RUN_PIX  = 3'd3,
    PH_SKIP_LEN = 3'd4
  } phase_e;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] color;
    logic       done;
  } result_t;

  // darkening map: green part of a 12-step colour cube raised by two, capped at 11
  function automatic logic [255:0][7:0] build_darken_map();
    logic [255:0][7:0] m;
    int g;
    int gd;
    g = 0;
    for (int c = 0; c < 256; c++) begin
      gd = (c == 0) ? 0 : ((g + 2 >= 12) ? 11 : g + 2);
      m[c] = 8'(c - g + gd);
      g = (g == 11) ? 0 : g + 1;
    end
    return m;
  endfunction

  localparam logic [255:0][7:0] DARKEN_MAP = build_darken_map();

endpackage

`default_nettype wire

>>> sv/rle_sprite_clip_blitter_top.sv
// top level of the run-length sprite clip blitter: decoder, clip registers, output queue
// depends on rscb_pkg
`timescale 1ns / 1ps
`default_nettype none

// Decodes run-length coded sprite rows into clipped pixel writes. A start request
// (req_type 0) loads the origin, frame height and darken flag; byte requests
// (req_type 1) carry one coded byte each. The decoder state updates at the accepting
// edge and the result, if any, is written into a two-entry output queue, so one request
// per clock is sustained while the queue has room (in_ready_o high).
// in_ready_o drops only when both queue entries hold results not yet taken, which
// decouples the input from stalls on the output. A rejected tile, the end opcode
// and a new row below the clip rectangle each give one result with tile_done set
// and zero coordinates. Clip registers sit on an APB-style port at byte addresses
// 0, 4, 8 and 12 (left, top, right, bottom) and should only be written while idle.
module rle_sprite_clip_blitter_top
  import rscb_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  // request channel
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               req_type_i,
  input  wire signed [11:0] origin_x_i,
  input  wire signed [11:0] origin_y_i,
  input  wire        [7:0]  frame_height_i,
  input  wire               darken_mode_i,
  input  wire        [7:0]  code_byte_i,
  // result channel
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic       [9:0]  pixel_x_o,
  output logic       [9:0]  pixel_y_o,
  output logic       [7:0]  pixel_color_o,
  output logic              tile_done_o,
  // config port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [3:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // clip registers
  // ---------------------------------------------------------------------------
  logic [9:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= CLIP_LEFT_RST;
      clip_top_q    <= CLIP_TOP_RST;
      clip_right_q  <= CLIP_RIGHT_RST;
      clip_bottom_q <= CLIP_BOTTOM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLIP_LEFT:   clip_left_q   <= pwdata[9:0];
        REG_CLIP_TOP:    clip_top_q    <= pwdata[9:0];
        REG_CLIP_RIGHT:  clip_right_q  <= pwdata[9:0];
        REG_CLIP_BOTTOM: clip_bottom_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (cfg_idx)
      REG_CLIP_LEFT:   prdata = {22'd0, clip_left_q};
      REG_CLIP_TOP:    prdata = {22'd0, clip_top_q};
      REG_CLIP_RIGHT:  prdata = {22'd0, clip_right_q};
      REG_CLIP_BOTTOM: prdata = {22'd0, clip_bottom_q};
      default:         prdata = 32'd0;
    endcase
  end

  // signed views of the clip bounds for compares against 12 bit coordinates
  logic signed [12:0] cl_s, ct_s, cr_s, cb_s;
  assign cl_s = signed'({3'b000, clip_left_q});
  assign ct_s = signed'({3'b000, clip_top_q});
  assign cr_s = signed'({3'b000, clip_right_q});
  assign cb_s = signed'({3'b000, clip_bottom_q});

  // ---------------------------------------------------------------------------
  // decoder state
  // ---------------------------------------------------------------------------
  phase_e             phase_q, phase_d;
  logic signed [11:0] cursor_x_q, cursor_x_d;
  logic signed [11:0] cursor_y_q, cursor_y_d;
  logic signed [11:0] row_start_x_q, row_start_x_d;
  logic        [7:0]  run_left_q, run_left_d;
  logic               run_visible_q, run_visible_d;
  logic               darken_on_q, darken_on_d;

  logic    in_fire;
  logic    res_valid;
  result_t res_d;

  // start request: moved origin row, saturated to 12 bits
  logic signed [13:0] start_y_wide;
  logic signed [11:0] start_y;
  logic signed [13:0] start_right_edge;
  logic               start_reject;

  assign start_y_wide = {{2{origin_y_i[11]}}, origin_y_i} + 14'(TILE_BASE_HEIGHT)
                      - {6'd0, frame_height_i};
  assign start_y = (start_y_wide > 14'(COORD_MAX)) ? COORD_MAX :
                   (start_y_wide < 14'(COORD_MIN)) ? COORD_MIN : start_y_wide[11:0];
  assign start_right_edge = {{2{origin_x_i[11]}}, origin_x_i} + 14'(TILE_WIDTH - 1);

  // tile lies wholly right of, below or left of the clip rectangle
  assign start_reject = (signed'({origin_x_i[11], origin_x_i}) > cr_s)
                      || (signed'({start_y[11], start_y}) > cb_s)
                      || (start_right_edge < 14'(cl_s));

  // next row, saturating
  logic signed [11:0] row_next_y;
  logic               row_past_bottom;
  assign row_next_y      = (cursor_y_q == COORD_MAX) ? COORD_MAX : cursor_y_q + 12'sd1;
  assign row_past_bottom = signed'({row_next_y[11], row_next_y}) > cb_s;

  // skip, only grows so only the top needs saturation
  logic signed [12:0] skip_sum;
  logic signed [11:0] skip_x;
  assign skip_sum = {cursor_x_q[11], cursor_x_q} + signed'({5'd0, code_byte_i});
  assign skip_x   = (skip_sum > 13'(COORD_MAX)) ? COORD_MAX : skip_sum[11:0];

  // run pixel column handling
  logic signed [11:0] pix_next_x;
  logic               pix_in_clip;
  logic [7:0]         pix_color;
  assign pix_next_x  = (cursor_x_q == COORD_MAX) ? COORD_MAX : cursor_x_q + 12'sd1;
  assign pix_in_clip = run_visible_q && (signed'({cursor_x_q[11], cursor_x_q}) >= cl_s)
                     && (signed'({cursor_x_q[11], cursor_x_q}) <= cr_s);
  assign pix_color   = darken_on_q ? DARKEN_MAP[code_byte_i] : code_byte_i;

  // visibility latched when a run opcode is read
  logic run_vis_now;
  assign run_vis_now = (signed'({cursor_y_q[11], cursor_y_q}) >= ct_s)
                    && (signed'({cursor_x_q[11], cursor_x_q}) <= cr_s);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (req_type_i == REQ_START) begin
      phase_d = start_reject ? PH_IDLE : PH_OPCODE;
    end else begin
      case (phase_q)
        PH_IDLE: phase_d = PH_IDLE;
        PH_OPCODE: begin
          case (code_byte_i)
            OP_RUN:    phase_d = PH_RUN_LEN;
            OP_SKIP:   phase_d = PH_SKIP_LEN;
            OP_NEWROW: phase_d = row_past_bottom ? PH_IDLE : PH_OPCODE;
            OP_END:    phase_d = PH_IDLE;
            default:   phase_d = PH_OPCODE;
          endcase
        end
        PH_RUN_LEN:  phase_d = (code_byte_i == 8'd0) ? PH_OPCODE : PH_RUN_PIX;
        PH_RUN_PIX:  phase_d = (run_left_q == 8'd1) ? PH_OPCODE : PH_RUN_PIX;
        PH_SKIP_LEN: phase_d = PH_OPCODE;
        default:     phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    cursor_x_d    = cursor_x_q;
    cursor_y_d    = cursor_y_q;
    row_start_x_d = row_start_x_q;
    run_left_d    = run_left_q;
    run_visible_d = run_visible_q;
    darken_on_d   = darken_on_q;
    res_valid     = 1'b0;
    res_d         = '0;
    if (req_type_i == REQ_START) begin
      row_start_x_d = origin_x_i;
      cursor_x_d    = origin_x_i;
      cursor_y_d    = start_y;
      darken_on_d   = darken_mode_i;
      run_left_d    = 8'd0;
      run_visible_d = 1'b0;
      if (start_reject) begin
        res_valid  = 1'b1;
        res_d.done = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_OPCODE: begin
          case (code_byte_i)
            OP_RUN: run_visible_d = run_vis_now;
            OP_NEWROW: begin
              cursor_x_d = row_start_x_q;
              cursor_y_d = row_next_y;
              if (row_past_bottom) begin
                res_valid  = 1'b1;
                res_d.done = 1'b1;
              end
            end
            OP_END: begin
              res_valid  = 1'b1;
              res_d.done = 1'b1;
            end
            default: ;
          endcase
        end
        PH_RUN_LEN: run_left_d = code_byte_i;
        PH_RUN_PIX: begin
          if (pix_in_clip) begin
            res_valid   = 1'b1;
            res_d.x     = cursor_x_q[9:0];
            res_d.y     = cursor_y_q[9:0];
            res_d.color = pix_color;
          end
          cursor_x_d = pix_next_x;
          run_left_d = run_left_q - 8'd1;
        end
        PH_SKIP_LEN: cursor_x_d = skip_x;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      cursor_x_q    <= '0;
      cursor_y_q    <= '0;
      row_start_x_q <= '0;
      run_left_q    <= '0;
      run_visible_q <= 1'b0;
      darken_on_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      cursor_x_q    <= cursor_x_d;
      cursor_y_q    <= cursor_y_d;
      row_start_x_q <= row_start_x_d;
      run_left_q    <= run_left_d;
      run_visible_q <= run_visible_d;
      darken_on_q   <= darken_on_d;
    end
  end

  // ---------------------------------------------------------------------------
  // two-entry output queue
  // ---------------------------------------------------------------------------
  result_t    queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  result_t    head;

  assign in_ready_o = (count_q != 2'd2);
  assign in_fire    = in_valid_i & in_ready_o;
  assign push       = in_fire & res_valid;
  assign pop        = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign head          = queue_q[rd_ptr_q];
  assign out_valid_o   = (count_q != 2'd0);
  assign pixel_x_o     = head.x;
  assign pixel_y_o     = head.y;
  assign pixel_color_o = head.color;
  assign tile_done_o   = head.done;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue count out of range");

  // a tile end always leaves the decoder idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res_d.done |=> phase_q == PH_IDLE)
    else $error("tile end did not return decoder to idle");

  // a literal run in progress always has pixels left
  a_run_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RUN_PIX |-> run_left_q != 8'd0)
    else $error("run pixel phase with empty run");

  // a stalled queue holds its head
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rd_ptr_q))
    else $error("queue head moved without being taken");

endmodule

`default_nettype wire

>>> test/tb.sv
// self-checking testbench for rle_sprite_clip_blitter_top: directed and random tile streams,
// predicted pixel writes and tile ends compared in order; depends on rscb_pkg and the top level
`timescale 1ns / 1ps

module tb;
  import rscb_pkg::*;

  // stimulus shape
  localparam int ITEM_GOAL  = 1850;  // live requests before the random part stops
  localparam int IDLE_PCT   = 9;     // chance of an idle gap on either side, per cent
  localparam int HOLD_LEN   = 240;   // long output hold, in cycles
  localparam int DRAIN_GAP  = 6;     // settle time after the last expected result
  localparam int SWEEP_ITEMS = 120;  // live requests per clip setting in the sweep

  // clock, reset and block connections
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_BYTE;
  logic [11:0] origin_x = '0;
  logic [11:0] origin_y = '0;
  logic [7:0]  frame_height = '0;
  logic        darken_mode = 1'b0;
  logic [7:0]  code_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [7:0]  pixel_color;
  logic        tile_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rle_sprite_clip_blitter_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .origin_x_i    (origin_x),
    .origin_y_i    (origin_y),
    .frame_height_i(frame_height),
    .darken_mode_i (darken_mode),
    .code_byte_i   (code_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .tile_done_o   (tile_done),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predictor state: decoder copy plus the clip rectangle as last written
  phase_e     phase = PH_IDLE;
  int         cur_x = 0;
  int         cur_y = 0;
  int         row_x = 0;
  int         run_cnt = 0;
  bit         run_vis = 1'b0;
  bit         dark_on = 1'b0;
  int         clip_l = CLIP_LEFT_RST;
  int         clip_t = CLIP_TOP_RST;
  int         clip_r = CLIP_RIGHT_RST;
  int         clip_b = CLIP_BOTTOM_RST;
  logic [7:0] shade_lut [256];

  // writes still owed by the block, oldest first
  result_t blit_q [$];

  // bookkeeping
  int  n_err = 0;
  int  n_req = 0;
  int  n_live = 0;
  int  n_pix = 0;
  int  n_done = 0;
  int  n_clip = 0;
  bit  steady = 1'b0;     // no idling on either side while set
  bit  stall_req = 1'b0;  // asks the receiver for one long hold

  // darkening map: colour split into a 12-step base and a green step, green raised by two
  initial begin
    for (int c = 0; c < 256; c++) begin
      int r;
      int g;
      r = c / 12;
      g = c % 12;
      if (c != 0) g = (g + 2 > 11) ? 11 : g + 2;
      shade_lut[c] = 8'(r * 12 + g);
    end
  end

  // free-running clock, 2 ns period
  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int fit_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  // uniform pick between two bounds, either order
  function automatic int pick(int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // one decoder step per accepted request; returns 1 when a write or tile end is owed
  function automatic bit blit_predict(input logic kind, input logic signed [11:0] ox,
                                      input logic signed [11:0] oy, input logic [7:0] h,
                                      input logic dk, input logic [7:0] b,
                                      output result_t res);
    int x;
    res = '0;
    if (kind == REQ_START) begin
      n_live++;
      row_x   = ox;
      cur_x   = ox;
      cur_y   = fit_coord(int'(oy) + int'(TILE_BASE_HEIGHT) - int'(h));
      dark_on = dk;
      run_cnt = 0;
      run_vis = 1'b0;
      // tile wholly off the rectangle: rejected straight away
      if (cur_x > clip_r || cur_y > clip_b || cur_x + int'(TILE_WIDTH) - 1 < clip_l) begin
        phase    = PH_IDLE;
        res.done = 1'b1;
        return 1'b1;
      end
      phase = PH_OPCODE;
      return 1'b0;
    end
    if (phase != PH_IDLE) n_live++;
    case (phase)
      PH_OPCODE: begin
        if (b == OP_RUN) begin
          run_vis = (cur_y >= clip_t) && (cur_x <= clip_r);
          phase   = PH_RUN_LEN;
        end else if (b == OP_SKIP) begin
          phase = PH_SKIP_LEN;
        end else if (b == OP_NEWROW) begin
          cur_x = row_x;
          cur_y = fit_coord(cur_y + 1);
          if (cur_y > clip_b) begin
            phase    = PH_IDLE;
            res.done = 1'b1;
            return 1'b1;
          end
        end else if (b == OP_END) begin
          phase    = PH_IDLE;
          res.done = 1'b1;
          return 1'b1;
        end
      end
      PH_RUN_LEN: begin
        run_cnt = int'(b);
        if (b == 8'd0) phase = PH_OPCODE;
        else phase = PH_RUN_PIX;
      end
      PH_RUN_PIX: begin
        x       = cur_x;
        cur_x   = fit_coord(x + 1);
        run_cnt = run_cnt - 1;
        if (run_cnt == 0) phase = PH_OPCODE;
        if (run_vis && x >= clip_l && x <= clip_r) begin
          res.x     = 10'(x);
          res.y     = 10'(cur_y);
          res.color = dark_on ? shade_lut[b] : b;
          return 1'b1;
        end
      end
      PH_SKIP_LEN: begin
        cur_x = fit_coord(cur_x + int'(b));
        phase = PH_OPCODE;
      end
      default: phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  task automatic report(input string what, input int got, input int want);
    n_err++;
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // offers one request and waits for the handshake; valid is left high for a follow-on request
  task automatic push_req(input logic kind, input logic [11:0] ox, input logic [11:0] oy,
                          input logic [7:0] h, input logic dk, input logic [7:0] b);
    result_t res;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    origin_x     <= ox;
    origin_y     <= oy;
    frame_height <= h;
    darken_mode  <= dk;
    code_byte    <= b;
    do @(posedge clk); while (!in_ready);
    n_req++;
    if (blit_predict(kind, ox, oy, h, dk, b, res)) blit_q.push_back(res);
  endtask

  // unused fields of each request carry random values
  task automatic send_start(input int ox, input int oy, input int h, input bit dk);
    push_req(REQ_START, 12'(fit_coord(ox)), 12'(fit_coord(oy)), 8'(h), dk, 8'($urandom));
  endtask

  task automatic send_byte(input int b);
    push_req(REQ_BYTE, 12'($urandom), 12'($urandom), 8'($urandom), 1'($urandom), 8'(b));
  endtask

  // drops valid and waits until every owed result has been taken, then lets the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (blit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // setup and access phase write, then a read back of the same register
  task automatic apb_write(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CLIP_LEFT:   clip_l = val;
      REG_CLIP_TOP:    clip_t = val;
      REG_CLIP_RIGHT:  clip_r = val;
      default:         clip_b = val;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[9:0] != 10'(val)) report("clip register read back", int'(prdata[9:0]), val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_clip(input int l, input int t, input int r, input int b);
    wait_drain();
    apb_write(REG_CLIP_LEFT, l);
    apb_write(REG_CLIP_TOP, t);
    apb_write(REG_CLIP_RIGHT, r);
    apb_write(REG_CLIP_BOTTOM, b);
    n_clip++;
  endtask

  // one tile near the clip rectangle; untidy tiles may be cut short or start anywhere
  task automatic send_tile(input bit tidy);
    int ox;
    int oy;
    int h;
    int len;
    int k;
    int op;
    bit dk;
    h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(24, 40);
    ox = pick(clip_l - 80, clip_r + 10);
    oy = pick(clip_t - 6, clip_b + 2) + h - int'(TILE_BASE_HEIGHT);
    if (!tidy && $urandom_range(0, 2) == 0) begin
      ox = pick(-2048, 2047);
      oy = pick(-2048, 2047);
    end
    dk = 1'($urandom);
    send_start(ox, oy, h, dk);
    repeat ($urandom_range(1, 12)) begin
      op = $urandom_range(0, 99);
      if (op < 50) begin
        if ($urandom_range(0, 29) == 0) len = 0;
        else if ($urandom_range(0, 39) == 0) len = $urandom_range(30, 255);
        else len = $urandom_range(1, 12);
        send_byte(OP_RUN);
        send_byte(len);
        k = (!tidy && $urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len;
        repeat (k) send_byte($urandom_range(0, 255));
        // stream cut inside a run: the next start abandons the tile
        if (k < len) return;
      end else if (op < 70) begin
        send_byte(OP_SKIP);
        send_byte(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16));
      end else if (op < 88) begin
        send_byte(OP_NEWROW);
      end else if (op < 94) begin
        send_byte($urandom_range(4, 255));
      end else begin
        send_byte($urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(OP_END);
    // stray bytes after the tile; the decoder ignores them only if it has gone idle
    if (!tidy && $urandom_range(0, 1) == 0) repeat ($urandom_range(1, 3)) send_byte($urandom);
  endtask

  task automatic run_tiles(input int goal);
    while (n_live < goal) send_tile($urandom_range(0, 4) != 0);
  endtask

  // short hand-picked stream under the reset rectangle
  task automatic test_directed();
    // plain tile: run of three with extreme colours, far skip, next row, unknown opcode,
    // zero-length run and end
    send_start(0, 0, 32, 0);
    send_byte(OP_RUN);
    send_byte(3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(OP_SKIP);
    send_byte(255);
    send_byte(OP_NEWROW);
    send_byte(8'hC3);
    send_byte(OP_RUN);
    send_byte(0);
    send_byte(OP_END);
    // byte with no tile open is dropped
    send_byte(OP_RUN);
    // rejected tiles: right of, left of and below the rectangle
    send_start(2047, 0, 32, 0);
    send_start(-2048, 0, 32, 1);
    send_start(0, 2047, 0, 0);
    // tallest frame pushes the tile above the top edge, so the run stays hidden
    send_start(-5, 0, 255, 1);
    send_byte(OP_RUN);
    send_byte(1);
    send_byte(8'h11);
    // new start mid-tile abandons the old one, darkened run follows
    send_start(10, 100, 32, 1);
    send_byte(OP_RUN);
    send_byte(2);
    send_byte(8'h5F);
    send_byte(8'h0B);
    // next row steps past the bottom edge
    send_start(0, 479, 32, 0);
    send_byte(OP_NEWROW);
  endtask

  // a tile whose cursor is skipped into the upper saturation limit
  task automatic send_saturating_tile();
    send_start(1000, 500, 32, 0);
    repeat (6) begin
      send_byte(OP_SKIP);
      send_byte(255);
    end
    send_byte(OP_RUN);
    send_byte(2);
    send_byte($urandom);
    send_byte($urandom);
    send_byte(OP_NEWROW);
    send_byte(OP_RUN);
    send_byte(1);
    send_byte($urandom);
    send_byte(OP_END);
  endtask

  // extreme and odd rectangles: full screen, corner pixel, origin pixel, empty, inner box, reset
  task automatic test_clip_sweep();
    int setting [6][4];
    setting = '{'{0, 0, 1023, 1023}, '{1023, 1023, 1023, 1023}, '{0, 0, 0, 0},
                '{700, 400, 90, 60}, '{17, 9, 600, 300}, '{0, 0, 639, 479}};
    foreach (setting[i]) begin
      set_clip(setting[i][0], setting[i][1], setting[i][2], setting[i][3]);
      if (i == 0) send_saturating_tile();
      run_tiles(n_live + SWEEP_ITEMS);
    end
  endtask

  // receiver holds off while a long visible run keeps arriving, so the block stalls its input
  task automatic test_receiver_hold();
    stall_req = 1'b1;
    send_start(40, 40, 32, 0);
    send_byte(OP_RUN);
    send_byte(60);
    repeat (60) send_byte($urandom);
    send_byte(OP_END);
    wait_drain();
  endtask

  // sender pauses until every owed result has arrived, then carries on
  task automatic test_sender_pause();
    run_tiles(n_live + 50);
    wait_drain();
    run_tiles(n_live + 50);
  endtask

  // back-to-back requests and an always-ready receiver
  task automatic test_steady_stream();
    steady = 1'b1;
    run_tiles(n_live + 200);
    steady = 1'b0;
  endtask

  // bulk random tiles, the rectangle moved now and then
  task automatic test_random_bulk();
    int l;
    int t;
    while (n_live < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) begin
        set_clip($urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        l = $urandom_range(0, 600);
        t = $urandom_range(0, 600);
        set_clip(l, t, l + $urandom_range(0, 1023 - l), t + $urandom_range(0, 1023 - t));
      end
      run_tiles(n_live + 260);
    end
  endtask

  // receiver: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        stall_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result check: every taken result against the oldest owed write
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (blit_q.size() == 0) begin
          report("result with nothing owed, x", int'(pixel_x), -1);
        end else begin
          want = blit_q.pop_front();
          if (want.done) n_done++;
          else n_pix++;
          if (tile_done != want.done) report("tile_done", int'(tile_done), int'(want.done));
          if (pixel_x != want.x) report("pixel_x", int'(pixel_x), int'(want.x));
          if (pixel_y != want.y) report("pixel_y", int'(pixel_y), int'(want.y));
          if (pixel_color != want.color) begin
            report("pixel_color", int'(pixel_color), int'(want.color));
          end
        end
      end
    end
  end

  // main sequence: reset once, then the tests in turn
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_clip_sweep();
    test_receiver_hold();
    test_sender_pause();
    test_steady_stream();
    test_random_bulk();
    wait_drain();
    $display("run covered %0d requests, %0d pixel writes and %0d tile ends checked",
             n_req, n_pix, n_done);
    $display("%0d clip rectangles applied, with a long output hold and a drained pause",
             n_clip);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> rle_sprite_clip_blitter_top.f
sv/rscb_pkg.sv
sv/rle_sprite_clip_blitter_top.sv
test/tb.sv
